// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Each macro expects a signal named clk in the enclosing scope; GRS_ASSERT also needs rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted
`define GRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset
`define GRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hdl/grs_pkg.sv
// ----------------------------------------------------------------------------
// grs_pkg: shared types, constants and helpers for the reaction step block
// Opcodes, register indexes, stoichiometry and saturating arithmetic.
// ----------------------------------------------------------------------------
package grs_pkg;

  localparam int BINS_DEFAULT = 256;
  localparam int TIME_W       = 48;
  localparam int CNT_W        = 16;
  localparam int NUM_SPECIES  = 4;
  localparam int NUM_REACT    = 10;

  localparam logic [47:0] MASK48   = 48'hFFFF_FFFF_FFFF;
  localparam logic [59:0] PROP_CAP = 60'hFFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] LN2_Q32  = 32'hB172_17F8;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [2:0] CFG_RATE_INFLOW  = 3'd0;
  localparam logic [2:0] CFG_RATE_EXCH    = 3'd1;
  localparam logic [2:0] CFG_RATE_PAIR    = 3'd2;
  localparam logic [2:0] CFG_RATE_A_TO_X  = 3'd3;
  localparam logic [2:0] CFG_RATE_B_REM_X = 3'd4;
  localparam logic [2:0] CFG_INIT_COUNT   = 3'd5;
  localparam logic [2:0] CFG_END_TIME     = 3'd6;

  // Stoichiometry per species (x, y, a, b) and reaction
  localparam logic signed [2:0] DELTA [NUM_SPECIES][NUM_REACT] = '{
    '{ 3'sd1, -3'sd1, -3'sd2,  3'sd2,  3'sd0,  3'sd1,  3'sd0,  3'sd0, -3'sd1,  3'sd0},
    '{ 3'sd0,  3'sd0,  3'sd1, -3'sd1,  3'sd0,  3'sd0,  3'sd0,  3'sd0,  3'sd0,  3'sd0},
    '{ 3'sd0,  3'sd0,  3'sd0,  3'sd0,  3'sd1,  3'sd0, -3'sd1,  3'sd0,  3'sd0,  3'sd0},
    '{ 3'sd0,  3'sd0,  3'sd0,  3'sd0,  3'sd0,  3'sd0,  3'sd0,  3'sd1,  3'sd0, -3'sd1}
  };

  function automatic logic [47:0] sat48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? MASK48 : s[47:0];
  endfunction

  function automatic logic [59:0] cap60(input logic [63:0] v);
    return (v > 64'(PROP_CAP)) ? PROP_CAP : v[59:0];
  endfunction

  function automatic logic [15:0] sat_apply(input logic [15:0] c,
                                            input logic signed [2:0] d);
    logic signed [17:0] n;
    n = $signed({2'b00, c}) + 18'(d);
    if (n < 0) return 16'd0;
    else if (n > 18'sd65535) return 16'hFFFF;
    else return n[15:0];
  endfunction

endpackage

// File: hdl/gillespie_reaction_step.sv
// ----------------------------------------------------------------------------
// gillespie_reaction_step: one direct-method stochastic simulation step
// Ten-reaction network over x, y, a, b with dwell-time histograms, built
// around one shared 32x32 multiplier and a small sequencer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | slave     | in_tvalid/in_tready  | tuser opcode, tdata operands
//  out_    | master    | out_tvalid/out_tready| tdata status, counts, time, dwell
//  cfg_    | write     | cfg_wr_en            | cfg_index, cfg_wdata
//
// Step: the propensity multiplies, sum, target, pick, normalise, log-bit
// squarings, log scale and bit-serial divide, then a histogram read and
// write; a zero total skips to the histogram update with saturated time.
// Read passes through a RAM wait state; idle opcodes go straight to the
// response. Reset and start run a clearing pass through the histograms;
// no transaction is accepted meanwhile.
// in_tready is high only in idle; a result waits in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gillespie_reaction_step #(
  parameter int BINS_X = grs_pkg::BINS_DEFAULT,
  parameter int BINS_Y = grs_pkg::BINS_DEFAULT,
  parameter int BINS_A = grs_pkg::BINS_DEFAULT,
  parameter int BINS_B = grs_pkg::BINS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [31:0] uniform_time, [63:32] uniform_choice, [65:64] species_select,
  // [73:66] bin_index
  input  logic [79:0]  in_tdata,
  // [1:0] opcode
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [3:0] reaction_fired, [4] step_taken, [5] run_done, [21:6] count_x_out,
  // [37:22] count_y_out, [53:38] count_a_out, [69:54] count_b_out,
  // [117:70] sim_time_out, [165:118] bin_dwell
  output logic [167:0] out_tdata,
  input  logic         cfg_wr_en,
  input  logic [2:0]   cfg_index,
  input  logic [47:0]  cfg_wdata
);

  import grs_pkg::*;

  localparam int BINS_ARR [NUM_SPECIES] = '{BINS_X, BINS_Y, BINS_A, BINS_B};
  localparam int MAXB_XY = (BINS_X > BINS_Y) ? BINS_X : BINS_Y;
  localparam int MAXB_AB = (BINS_A > BINS_B) ? BINS_A : BINS_B;
  localparam int MAXB    = (MAXB_XY > MAXB_AB) ? MAXB_XY : MAXB_AB;
  localparam int CW      = $clog2(MAXB);

  typedef enum logic [12:0] {
    S_CLEAR  = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_MUL    = 13'b0000000000100,
    S_SUM    = 13'b0000000001000,
    S_TGT    = 13'b0000000010000,
    S_PICK   = 13'b0000000100000,
    S_NORM   = 13'b0000001000000,
    S_SQ     = 13'b0000010000000,
    S_LN     = 13'b0000100000000,
    S_DIV    = 13'b0001000000000,
    S_RDWAIT = 13'b0010000000000,
    S_BINWR  = 13'b0100000000000,
    S_RESP   = 13'b1000000000000
  } state_t;

  // configuration
  logic [31:0] rate_inflow_r, rate_exch_r, rate_pair_r, rate_a_to_x_r, rate_b_rem_x_r;
  logic [15:0] init_cnt_r;
  logic [47:0] end_time_r;

  // control and model state
  state_t        state_r, state_nxt;
  logic [5:0]    k_r, k_nxt;
  logic [CW-1:0] clr_r, clr_nxt;
  logic          clr_resp_r, clr_resp_nxt;
  logic          out_tvalid_r, out_tvalid_nxt;
  logic [15:0]   cnt_r [NUM_SPECIES];
  logic [15:0]   cnt_nxt [NUM_SPECIES];
  logic [47:0]   sim_time_r, sim_time_nxt;

  // payload
  logic [1:0]    op_r, op_nxt;
  logic [31:0]   r1_r, r1_nxt, r2_r, r2_nxt;
  logic [1:0]    sel_r, sel_nxt;
  logic [7:0]    bin_r, bin_nxt;
  logic          taken_r, taken_nxt, picked_r, picked_nxt;
  logic [3:0]    pick_r, pick_nxt;
  logic [31:0]   xx_r, xx_nxt, bx_r, bx_nxt;
  logic [59:0]   a2_r, a2_nxt, a8_r, a8_nxt;
  logic [47:0]   ey_r, ey_nxt, a5_r, a5_nxt, a6_r, a6_nxt, a9_r, a9_nxt;
  logic [63:0]   total_r, total_nxt, tgt_r, tgt_nxt, cum_r, cum_nxt;
  logic [31:0]   z_r, z_nxt;
  logic [4:0]    p_r, p_nxt;
  logic [23:0]   f_r, f_nxt;
  logic [47:0]   num_r, num_nxt, q_r, q_nxt;
  logic [63:0]   rem_r, rem_nxt;
  logic [167:0]  out_tdata_r, out_tdata_nxt;

  // shared multiplier and helpers
  logic [31:0]   mul_a, mul_b;
  logic [63:0]   prod;
  logic [63:0]   alpha_k;
  logic [32:0]   sq_s;
  logic [29:0]   neg2;
  logic [64:0]   rem_sh;
  logic          div_ge;
  logic [47:0]   rdata [NUM_SPECIES];
  logic          rd_ok [NUM_SPECIES];
  logic [47:0]   dwell;
  logic [3:0]    fired;

  assign prod   = 64'(mul_a) * 64'(mul_b);
  assign sq_s   = prod[63:31];
  assign neg2   = 30'h2000_0000 - 30'({p_r, 24'd0} + 29'(f_r));
  assign rem_sh = {rem_r, num_r[47]};
  assign div_ge = rem_sh >= {1'b0, total_r};

  // propensity of reaction k_r
  always_comb begin
    unique case (k_r[3:0])
      4'd0:    alpha_k = 64'(rate_inflow_r);
      4'd1:    alpha_k = 64'({cnt_r[0], 16'd0});
      4'd2:    alpha_k = 64'(a2_r);
      4'd3:    alpha_k = 64'(ey_r);
      4'd4:    alpha_k = 64'(ey_r);
      4'd5:    alpha_k = 64'(a5_r);
      4'd6:    alpha_k = 64'(a6_r);
      4'd7:    alpha_k = 64'(ey_r);
      4'd8:    alpha_k = 64'(a8_r);
      4'd9:    alpha_k = 64'(a9_r);
      default: alpha_k = 64'd0;
    endcase
  end

  // multiplier operand selection
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (state_r)
      S_MUL: begin
        unique case (k_r[2:0])
          3'd0: begin mul_a = 32'(cnt_r[0]); mul_b = 32'(cnt_r[0] - 16'd1); end
          3'd1: begin mul_a = 32'(cnt_r[3]); mul_b = 32'(cnt_r[0]); end
          3'd2: begin mul_a = xx_r;          mul_b = rate_pair_r; end
          3'd3: begin mul_a = bx_r;          mul_b = rate_b_rem_x_r; end
          3'd4: begin mul_a = 32'(cnt_r[1]); mul_b = rate_exch_r; end
          3'd5: begin mul_a = 32'(cnt_r[2]); mul_b = rate_a_to_x_r; end
          3'd6: begin mul_a = 32'(cnt_r[2]); mul_b = rate_exch_r; end
          3'd7: begin mul_a = 32'(cnt_r[3]); mul_b = rate_exch_r; end
        endcase
      end
      S_TGT: begin
        mul_a = r2_r;
        mul_b = k_r[0] ? total_r[31:0] : total_r[63:32];
      end
      S_SQ: begin
        mul_a = z_r;
        mul_b = z_r;
      end
      S_LN: begin
        mul_a = 32'(neg2);
        mul_b = LN2_Q32;
      end
      default: ;
    endcase
  end

  // histogram memories
  for (genvar g = 0; g < NUM_SPECIES; g++) begin : g_hist
    localparam int BG  = BINS_ARR[g];
    localparam int AWG = $clog2(BG);
    logic           we;
    logic [AWG-1:0] wa, ra;
    logic [47:0]    wd;

    assign we = (state_r == S_CLEAR) ? (32'(clr_r) < BG)
                                     : ((state_r == S_BINWR) && (32'(cnt_r[g]) < BG));
    assign wa = (state_r == S_CLEAR) ? clr_r[AWG-1:0] : cnt_r[g][AWG-1:0];
    assign wd = (state_r == S_CLEAR) ? 48'd0 : sat48(rdata[g], q_r);
    assign ra = (op_r == OP_READ) ? AWG'(bin_r) : cnt_r[g][AWG-1:0];
    assign rd_ok[g] = 32'(bin_r) < BG;

    grs_ram #(.WIDTH(TIME_W), .DEPTH(BG)) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (wa),
      .wdata (wd),
      .raddr (ra),
      .rdata (rdata[g])
    );
  end

  assign dwell = ((op_r == OP_READ) && rd_ok[sel_r]) ? rdata[sel_r] : 48'd0;
  assign fired = picked_r ? pick_r : 4'd0;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    clr_nxt        = clr_r;
    clr_resp_nxt   = clr_resp_r;
    out_tvalid_nxt = out_tvalid_r;
    cnt_nxt        = cnt_r;
    sim_time_nxt   = sim_time_r;
    op_nxt         = op_r;
    r1_nxt         = r1_r;
    r2_nxt         = r2_r;
    sel_nxt        = sel_r;
    bin_nxt        = bin_r;
    taken_nxt      = taken_r;
    picked_nxt     = picked_r;
    pick_nxt       = pick_r;
    xx_nxt         = xx_r;
    bx_nxt         = bx_r;
    a2_nxt         = a2_r;
    a8_nxt         = a8_r;
    ey_nxt         = ey_r;
    a5_nxt         = a5_r;
    a6_nxt         = a6_r;
    a9_nxt         = a9_r;
    total_nxt      = total_r;
    tgt_nxt        = tgt_r;
    cum_nxt        = cum_r;
    z_nxt          = z_r;
    p_nxt          = p_r;
    f_nxt          = f_r;
    num_nxt        = num_r;
    q_nxt          = q_r;
    rem_nxt        = rem_r;
    out_tdata_nxt  = out_tdata_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CW'(MAXB - 1)) begin
          state_nxt    = clr_resp_r ? S_RESP : S_IDLE;
          clr_resp_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt     = in_tuser;
          r1_nxt     = in_tdata[31:0];
          r2_nxt     = in_tdata[63:32];
          sel_nxt    = in_tdata[65:64];
          bin_nxt    = in_tdata[73:66];
          taken_nxt  = 1'b0;
          picked_nxt = 1'b0;
          pick_nxt   = 4'd0;
          k_nxt      = 6'd0;
          unique case (in_tuser)
            OP_START: begin
              for (int s = 0; s < NUM_SPECIES; s++) cnt_nxt[s] = init_cnt_r;
              sim_time_nxt = 48'd0;
              clr_nxt      = '0;
              clr_resp_nxt = 1'b1;
              state_nxt    = S_CLEAR;
            end
            OP_STEP:  state_nxt = (sim_time_r < end_time_r) ? S_MUL : S_RESP;
            OP_READ:  state_nxt = S_RDWAIT;
            default:  state_nxt = S_RESP;
          endcase
        end
      end
      S_MUL: begin
        unique case (k_r[2:0])
          3'd0: xx_nxt = prod[31:0];
          3'd1: bx_nxt = prod[31:0];
          3'd2: a2_nxt = cap60(prod);
          3'd3: a8_nxt = cap60(prod);
          3'd4: ey_nxt = prod[47:0];
          3'd5: a5_nxt = prod[47:0];
          3'd6: a6_nxt = prod[47:0];
          3'd7: a9_nxt = prod[47:0];
        endcase
        k_nxt = k_r + 6'd1;
        if (k_r == 6'd7) begin
          k_nxt     = 6'd0;
          total_nxt = 64'd0;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        total_nxt = total_r + alpha_k;
        k_nxt     = k_r + 6'd1;
        if (k_r == 6'd9) begin
          k_nxt = 6'd0;
          if (total_nxt == 64'd0) begin
            // nothing can fire: waiting time saturates
            q_nxt     = MASK48;
            state_nxt = S_RDWAIT;
          end else begin
            state_nxt = S_TGT;
          end
        end
      end
      S_TGT: begin
        k_nxt = k_r + 6'd1;
        if (k_r == 6'd0) begin
          tgt_nxt = prod;
        end else begin
          tgt_nxt   = tgt_r + 64'(prod[63:32]);
          k_nxt     = 6'd0;
          cum_nxt   = 64'd0;
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        cum_nxt = cum_r + alpha_k;
        k_nxt   = k_r + 6'd1;
        if (tgt_r < cum_nxt || k_r == 6'd9) begin
          picked_nxt = tgt_r < cum_nxt;
          pick_nxt   = k_r[3:0];
          z_nxt      = (r1_r == 32'd0) ? 32'd1 : r1_r;
          p_nxt      = 5'd31;
          k_nxt      = 6'd0;
          state_nxt  = S_NORM;
        end
      end
      S_NORM: begin
        if (z_r[31]) begin
          f_nxt     = 24'd0;
          k_nxt     = 6'd0;
          state_nxt = S_SQ;
        end else begin
          z_nxt = {z_r[30:0], 1'b0};
          p_nxt = p_r - 5'd1;
        end
      end
      S_SQ: begin
        // square the mantissa; an overflow past 2 yields the next log bit
        if (sq_s[32]) begin
          z_nxt = sq_s[32:1];
          f_nxt = {f_r[22:0], 1'b1};
        end else begin
          z_nxt = sq_s[31:0];
          f_nxt = {f_r[22:0], 1'b0};
        end
        k_nxt = k_r + 6'd1;
        if (k_r == 6'd23) begin
          state_nxt = S_LN;
        end
      end
      S_LN: begin
        num_nxt   = {prod[63:32], 16'd0};
        rem_nxt   = 64'd0;
        q_nxt     = 48'd0;
        k_nxt     = 6'd0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = div_ge ? 64'(rem_sh - {1'b0, total_r}) : rem_sh[63:0];
        q_nxt   = {q_r[46:0], div_ge};
        num_nxt = {num_r[46:0], 1'b0};
        k_nxt   = k_r + 6'd1;
        if (k_r == 6'd47) begin
          state_nxt = S_RDWAIT;
        end
      end
      S_RDWAIT: begin
        state_nxt = (op_r == OP_READ) ? S_RESP : S_BINWR;
      end
      S_BINWR: begin
        sim_time_nxt = sat48(sim_time_r, q_r);
        if (picked_r) begin
          for (int s = 0; s < NUM_SPECIES; s++) begin
            cnt_nxt[s] = sat_apply(cnt_r[s], DELTA[s][pick_r]);
          end
        end
        taken_nxt = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {2'b00, dwell, sim_time_r, cnt_r[3], cnt_r[2], cnt_r[1],
                            cnt_r[0], (sim_time_r >= end_time_r), taken_r, fired};
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      k_r          <= '0;
      clr_r        <= '0;
      clr_resp_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
      for (int s = 0; s < NUM_SPECIES; s++) cnt_r[s] <= 16'd0;
      sim_time_r   <= 48'd0;
    end else begin
      state_r      <= state_nxt;
      k_r          <= k_nxt;
      clr_r        <= clr_nxt;
      clr_resp_r   <= clr_resp_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      cnt_r        <= cnt_nxt;
      sim_time_r   <= sim_time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    r1_r        <= r1_nxt;
    r2_r        <= r2_nxt;
    sel_r       <= sel_nxt;
    bin_r       <= bin_nxt;
    taken_r     <= taken_nxt;
    picked_r    <= picked_nxt;
    pick_r      <= pick_nxt;
    xx_r        <= xx_nxt;
    bx_r        <= bx_nxt;
    a2_r        <= a2_nxt;
    a8_r        <= a8_nxt;
    ey_r        <= ey_nxt;
    a5_r        <= a5_nxt;
    a6_r        <= a6_nxt;
    a9_r        <= a9_nxt;
    total_r     <= total_nxt;
    tgt_r       <= tgt_nxt;
    cum_r       <= cum_nxt;
    z_r         <= z_nxt;
    p_r         <= p_nxt;
    f_r         <= f_nxt;
    num_r       <= num_nxt;
    q_r         <= q_nxt;
    rem_r       <= rem_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_inflow_r  <= 32'h0001_0000;
      rate_exch_r    <= 32'h0001_0000;
      rate_pair_r    <= 32'h0001_0000;
      rate_a_to_x_r  <= 32'h0001_0000;
      rate_b_rem_x_r <= 32'h0001_0000;
      init_cnt_r     <= 16'd0;
      end_time_r     <= 48'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_RATE_INFLOW:  rate_inflow_r  <= cfg_wdata[31:0];
        CFG_RATE_EXCH:    rate_exch_r    <= cfg_wdata[31:0];
        CFG_RATE_PAIR:    rate_pair_r    <= cfg_wdata[31:0];
        CFG_RATE_A_TO_X:  rate_a_to_x_r  <= cfg_wdata[31:0];
        CFG_RATE_B_REM_X: rate_b_rem_x_r <= cfg_wdata[31:0];
        CFG_INIT_COUNT:   init_cnt_r     <= cfg_wdata[15:0];
        CFG_END_TIME:     end_time_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `GRS_ASSERT(a_start_clears, in_tvalid && in_tready && (in_tuser == OP_START) |=> (state_r == S_CLEAR) && (sim_time_r == 48'd0), "start did not enter clearing pass")
  `GRS_ASSERT(a_div_nonzero, (state_r == S_DIV) |-> (total_r != 64'd0), "divide by zero total propensity")
  `GRS_ASSERT(a_time_mono, !(in_tvalid && in_tready && (in_tuser == OP_START)) |=> (sim_time_r >= $past(sim_time_r)), "simulated time went backwards")

endmodule

// File: hdl/grs_ram.sv
// ----------------------------------------------------------------------------
// grs_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module grs_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
